@@ hw/rtl/kwl_pkg.sv @@
package kwl_pkg;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_TEXT = 2'd0,
    REQ_LOAD = 2'd1,
    REQ_END  = 2'd2
  } req_t;

  // Token kinds carried on the output tuser.
  typedef enum logic [2:0] {
    TK_NULL    = 3'd0,
    TK_KEYWORD = 3'd1,
    TK_IDENT   = 3'd2,
    TK_INT     = 3'd3,
    TK_SEP     = 3'd4,
    TK_OPER    = 3'd5
  } tok_kind_t;

  // Byte classes worked out by the front end.
  typedef enum logic [2:0] {
    CL_OTHER = 3'd0,
    CL_WORD  = 3'd1,
    CL_SEP   = 3'd2,
    CL_OPER  = 3'd3,
    CL_HOLD  = 3'd4
  } char_class_t;

  // Operator held back for one byte to see whether '=' follows.
  typedef enum logic [2:0] {
    HOLD_NONE = 3'd0,
    HOLD_BANG = 3'd1,
    HOLD_EQ   = 3'd2,
    HOLD_LT   = 3'd3,
    HOLD_GT   = 3'd4
  } hold_t;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;
  localparam logic [7:0] CH_DIG_0  = 8'h30;
  localparam logic [7:0] CH_DIG_9  = 8'h39;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // One classified input item as it waits in the queue.
  typedef struct packed {
    req_t        req;
    logic [7:0]  ch;
    logic [3:0]  slot;
    logic [2:0]  pos;
    char_class_t cls;
    hold_t       hold;
    tok_kind_t   wkind;
  } item_t;

  // One result token.
  typedef struct packed {
    tok_kind_t   kind;
    logic [31:0] offset;
    logic [15:0] length;
    logic        last;
  } tok_t;

endpackage

@@ hw/rtl/kwl_front.sv @@
module kwl_front (
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,
  input  logic [1:0]         in_tuser,
  input  logic               q_full,
  output logic               q_push,
  output kwl_pkg::item_t     q_item
);
  import kwl_pkg::*;

  logic [7:0] ch;
  logic       is_lower;
  logic       is_digit;

  assign ch       = in_tdata[7:0];
  assign is_lower = (ch >= CH_LC_A) && (ch <= CH_LC_Z);
  assign is_digit = (ch >= CH_DIG_0) && (ch <= CH_DIG_9);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item       = '0;
    q_item.req   = req_t'(in_tuser);
    q_item.ch    = ch;
    q_item.slot  = in_tdata[11:8];
    q_item.pos   = in_tdata[14:12];
    q_item.hold  = HOLD_NONE;
    q_item.wkind = is_digit ? TK_INT : (is_lower ? TK_IDENT : TK_NULL);
    if (is_lower || is_digit || ch == CH_USCORE) begin
      q_item.cls = CL_WORD;
    end else if (ch == CH_COMMA || ch == CH_SEMI || ch == CH_LPAREN ||
                 ch == CH_RPAREN || ch == CH_LBRACE || ch == CH_RBRACE) begin
      q_item.cls = CL_SEP;
    end else if (ch == CH_PLUS || ch == CH_STAR || ch == CH_SLASH || ch == CH_MINUS) begin
      q_item.cls = CL_OPER;
    end else if (ch == CH_BANG) begin
      q_item.cls  = CL_HOLD;
      q_item.hold = HOLD_BANG;
    end else if (ch == CH_EQ) begin
      q_item.cls  = CL_HOLD;
      q_item.hold = HOLD_EQ;
    end else if (ch == CH_LT) begin
      q_item.cls  = CL_HOLD;
      q_item.hold = HOLD_LT;
    end else if (ch == CH_GT) begin
      q_item.cls  = CL_HOLD;
      q_item.hold = HOLD_GT;
    end else begin
      q_item.cls = CL_OTHER;
    end
  end

endmodule

@@ hw/rtl/kwl_queue.sv @@
module kwl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  kwl_pkg::item_t     push_item,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output kwl_pkg::item_t     head_item
);
  import kwl_pkg::*;

  item_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (!push && do_pop) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hw/rtl/kwl_back.sv @@
module kwl_back #(
  parameter int KEYWORD_SLOTS     = 16,
  parameter int KEYWORD_MAX_CHARS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  kwl_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output kwl_pkg::tok_t      out_tok
);
  import kwl_pkg::*;

  localparam logic [15:0] MAX16 = 16'(KEYWORD_MAX_CHARS);

  logic [7:0]  kw_r  [KEYWORD_SLOTS][KEYWORD_MAX_CHARS];
  logic        kwv_r [KEYWORD_SLOTS];
  logic [7:0]  buf_r [KEYWORD_MAX_CHARS];

  logic [31:0] pos_r, pos_nxt;
  logic [31:0] begin_r, begin_nxt;
  logic [15:0] count_r, count_nxt;
  logic        overlong_r, overlong_nxt;
  logic        inword_r, inword_nxt;
  tok_kind_t   wkind_r, wkind_nxt;
  hold_t       held_r, held_nxt;

  tok_t        tok0_r, tok1_r;
  logic [1:0]  tcnt_r;

  logic        go;
  logic        match_any;
  logic        held_emit;
  tok_t        word_tok, held_tok, lead_tok, own_tok, t0, t1;
  logic        lead_v, own_v;
  logic [1:0]  n_tok;
  logic        buf_we;
  logic [15:0] c_eff;
  logic        kw_we;

  assign out_valid = (tcnt_r != 2'd0);
  assign out_tok   = tok0_r;
  // Take an item only when both token slots will be free after this cycle.
  assign q_pop     = (tcnt_r == 2'd0) || (tcnt_r == 2'd1 && out_ready);
  assign go        = q_valid && q_pop;

  // Whole-word compare against every valid keyword slot.
  always_comb begin
    logic eq_all;
    logic term;
    match_any = 1'b0;
    for (int s = 0; s < KEYWORD_SLOTS; s++) begin
      eq_all = 1'b1;
      term   = (count_r == MAX16);
      for (int p = 0; p < KEYWORD_MAX_CHARS; p++) begin
        if (count_r > 16'(p) && kw_r[s][p] != buf_r[p]) begin
          eq_all = 1'b0;
        end
        if (count_r == 16'(p) && kw_r[s][p] == 8'd0) begin
          term = 1'b1;
        end
      end
      match_any = match_any | (kwv_r[s] & eq_all & term);
    end
  end

  assign held_emit = (held_r != HOLD_NONE) && (held_r != HOLD_BANG);

  always_comb begin
    word_tok        = '0;
    word_tok.kind   = (!overlong_r && count_r != 16'd0 && count_r <= MAX16 && match_any)
                      ? TK_KEYWORD : wkind_r;
    word_tok.offset = begin_r;
    word_tok.length = count_r;
    held_tok        = '0;
    held_tok.kind   = TK_OPER;
    held_tok.offset = 32'(pos_r - 32'd1);
    held_tok.length = 16'd1;
  end

  always_comb begin
    pos_nxt      = pos_r;
    begin_nxt    = begin_r;
    count_nxt    = count_r;
    overlong_nxt = overlong_r;
    inword_nxt   = inword_r;
    wkind_nxt    = wkind_r;
    held_nxt     = held_r;
    lead_v       = 1'b0;
    lead_tok     = held_emit ? held_tok : word_tok;
    own_v        = 1'b0;
    own_tok      = '0;
    buf_we       = 1'b0;
    c_eff        = inword_r ? count_r : 16'd0;
    kw_we        = 1'b0;
    case (q_item.req)
      REQ_TEXT: begin
        pos_nxt = 32'(pos_r + 32'd1);
        if (held_r != HOLD_NONE && q_item.ch == CH_EQ) begin
          // Held operator and '=' form a two-byte operator.
          own_v          = 1'b1;
          own_tok.kind   = TK_OPER;
          own_tok.offset = 32'(pos_r - 32'd1);
          own_tok.length = 16'd2;
          held_nxt       = HOLD_NONE;
        end else begin
          held_nxt = HOLD_NONE;
          lead_v   = held_emit || (inword_r && q_item.cls != CL_WORD);
          if (q_item.cls == CL_WORD) begin
            if (!inword_r) begin
              inword_nxt   = 1'b1;
              begin_nxt    = pos_r;
              overlong_nxt = 1'b0;
              wkind_nxt    = q_item.wkind;
            end
            if (c_eff < MAX16) begin
              buf_we = 1'b1;
            end else begin
              overlong_nxt = 1'b1;
            end
            count_nxt = (c_eff == LEN_MAX) ? c_eff : 16'(c_eff + 16'd1);
          end else begin
            inword_nxt   = 1'b0;
            count_nxt    = 16'd0;
            overlong_nxt = 1'b0;
            case (q_item.cls)
              CL_SEP: begin
                own_v          = 1'b1;
                own_tok.kind   = TK_SEP;
                own_tok.offset = pos_r;
                own_tok.length = 16'd1;
              end
              CL_OPER: begin
                own_v          = 1'b1;
                own_tok.kind   = TK_OPER;
                own_tok.offset = pos_r;
                own_tok.length = 16'd1;
              end
              CL_HOLD: begin
                held_nxt = q_item.hold;
              end
              default: begin
              end
            endcase
          end
        end
      end
      REQ_LOAD: begin
        kw_we = 1'b1;
      end
      REQ_END: begin
        lead_v         = held_emit || inword_r;
        own_v          = 1'b1;
        own_tok.kind   = TK_NULL;
        own_tok.offset = pos_r;
        own_tok.length = 16'd0;
        own_tok.last   = 1'b1;
        pos_nxt        = 32'd0;
        begin_nxt      = 32'd0;
        held_nxt       = HOLD_NONE;
        inword_nxt     = 1'b0;
        count_nxt      = 16'd0;
        overlong_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
    t0    = lead_v ? lead_tok : own_tok;
    t1    = own_tok;
    n_tok = 2'({1'b0, lead_v} + {1'b0, own_v});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      begin_r    <= '0;
      count_r    <= '0;
      overlong_r <= 1'b0;
      inword_r   <= 1'b0;
      wkind_r    <= TK_NULL;
      held_r     <= HOLD_NONE;
      tcnt_r     <= 2'd0;
    end else begin
      if (go) begin
        pos_r      <= pos_nxt;
        begin_r    <= begin_nxt;
        count_r    <= count_nxt;
        overlong_r <= overlong_nxt;
        inword_r   <= inword_nxt;
        wkind_r    <= wkind_nxt;
        held_r     <= held_nxt;
        tcnt_r     <= n_tok;
      end else if (out_valid && out_ready) begin
        tcnt_r <= 2'(tcnt_r - 2'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      tok0_r <= t0;
      tok1_r <= t1;
    end else if (out_valid && out_ready) begin
      tok0_r <= tok1_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int p = 0; p < KEYWORD_MAX_CHARS; p++) begin
      if (go && buf_we && c_eff == 16'(p)) begin
        buf_r[p] <= q_item.ch;
      end
    end
  end

  // Keyword table; loads outside the table are dropped by the index match.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < KEYWORD_SLOTS; s++) begin
        kwv_r[s] <= 1'b0;
        for (int p = 0; p < KEYWORD_MAX_CHARS; p++) begin
          kw_r[s][p] <= 8'd0;
        end
      end
    end else begin
      for (int s = 0; s < KEYWORD_SLOTS; s++) begin
        for (int p = 0; p < KEYWORD_MAX_CHARS; p++) begin
          if (go && kw_we && int'(q_item.slot) == s && int'(q_item.pos) == p) begin
            kw_r[s][p] <= q_item.ch;
            kwv_r[s]   <= 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/keyword_token_lexer.sv @@
// Streaming keyword lexer. Text arrives one byte per item on the in_ channel;
// in_tuser says whether the item is a text byte, a keyword table character
// load or the end of a text. Tokens leave on the out_ channel as kind (tuser),
// offset and length (tdata), with tlast marking the closing zero-length null
// token of each text. One item can give at most two tokens.
// A front stage classifies each byte and writes it into a four-item queue;
// the back stage runs the word and operator state, compares a finished word
// with every keyword slot at once and loads a two-token output buffer.
// An accepted item is registered in the queue and then in the output buffer
// before it gives its first token. The back stage takes one item per cycle
// while the receiver keeps up; an item that gives two tokens holds it until
// its first token has left. Reset clears the keyword table, the word state and
// the byte position; the table survives an end of text. When the receiver stalls,
// tokens stay in the output buffer, the back stage stops taking items and the queue
// absorbs up to four more items before in_tready falls.
module keyword_token_lexer #(
  parameter int KEYWORD_SLOTS     = 16,
  parameter int KEYWORD_MAX_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // char_code[7:0], kw_slot[11:8], kw_pos[14:12], zero[15]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // token_offset[31:0], token_length[47:32]
  output logic [2:0]  out_tuser,  // token_kind[2:0]
  output logic        out_tlast   // last_token
);
  import kwl_pkg::*;

  logic  q_full;
  logic  q_push;
  item_t q_in_item;
  logic  q_pop;
  logic  q_valid;
  item_t q_head;
  tok_t  tok;

  // Byte classification in front of the queue.
  kwl_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_in_item)
  );

  // Short queue that lets the front accept while the back is held up.
  kwl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  // Lexer state, keyword table and output buffer.
  kwl_back #(
    .KEYWORD_SLOTS     (KEYWORD_SLOTS),
    .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (tok)
  );

  // Token fields onto the bus, offset in the low bits.
  assign out_tdata = {tok.length, tok.offset};
  assign out_tuser = tok.kind;
  assign out_tlast = tok.last;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import kwl_pkg::*;

  localparam int SLOTS          = 16;
  localparam int MAX_CHARS      = 8;
  localparam int PHASE_ITEMS    = 630;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 1500000;

  // The request code that the block is required to ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_UC_A = 8'h41;
  localparam logic [7:0] CH_TOP = 8'hFF;

  // Bytes that become separator or operator tokens, or that are held.
  localparam logic [7:0] PUNCT [14] = '{CH_COMMA, CH_SEMI, CH_LPAREN, CH_RPAREN,
                                        CH_LBRACE, CH_RBRACE, CH_PLUS, CH_STAR,
                                        CH_SLASH, CH_MINUS, CH_BANG, CH_EQ,
                                        CH_LT, CH_GT};
  // Space, tab, newline, vertical tab, form feed and carriage return.
  localparam logic [7:0] BLANKS [6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};

  // One directed stimulus row. Where typed is set, tok is the single token that
  // the row must give; every other row is checked against the token predictor.
  typedef struct packed {
    logic [1:0] req;
    logic [7:0] ch;
    logic [3:0] slot;
    logic [2:0] pos;
    logic       typed;
    tok_t       tok;
  } stim_row_t;

  localparam tok_t NO_TOKEN = '0;

  localparam stim_row_t DIRECTED_ROWS [25] = '{
    // End of text straight after reset: only the closing null token at 0.
    '{REQ_END,  CH_NUL,    4'd0,  3'd0, 1'b1, '{TK_NULL, 32'd0, 16'd0, 1'b1}},
    '{REQ_TEXT, CH_COMMA,  4'd0,  3'd0, 1'b1, '{TK_SEP,  32'd0, 16'd1, 1'b0}},
    '{REQ_TEXT, CH_PLUS,   4'd15, 3'd7, 1'b1, '{TK_OPER, 32'd1, 16'd1, 1'b0}},
    // Load "if" into the lowest slot, and a top byte at the far corner.
    '{REQ_LOAD, 8'h69,     4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_LOAD, 8'h66,     4'd0,  3'd1, 1'b0, NO_TOKEN},
    '{REQ_LOAD, CH_NUL,    4'd0,  3'd2, 1'b0, NO_TOKEN},
    '{REQ_LOAD, CH_TOP,    4'd15, 3'd7, 1'b0, NO_TOKEN},
    // "if(" gives a keyword and a separator from one byte.
    '{REQ_TEXT, 8'h69,     4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_TEXT, 8'h66,     4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_TEXT, CH_LPAREN, 4'd0,  3'd0, 1'b0, NO_TOKEN},
    // "0_<=" : an integer literal, then a two-byte operator.
    '{REQ_TEXT, CH_DIG_0,  4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_TEXT, CH_USCORE, 4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_TEXT, CH_LT,     4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_TEXT, CH_EQ,     4'd0,  3'd0, 1'b0, NO_TOKEN},
    // "_z!a" : an underscore word has the null kind, and a lone bang is dropped.
    '{REQ_TEXT, CH_USCORE, 4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_TEXT, CH_LC_Z,   4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_TEXT, CH_BANG,   4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_TEXT, CH_LC_A,   4'd0,  3'd0, 1'b0, NO_TOKEN},
    // Upper case and the top byte are skipped, but still move the offset on.
    '{REQ_TEXT, CH_UC_A,   4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_TEXT, CH_TOP,    4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_UNUSED, CH_TOP,  4'd15, 3'd7, 1'b0, NO_TOKEN},
    '{REQ_TEXT, CH_EQ,     4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_TEXT, CH_EQ,     4'd0,  3'd0, 1'b0, NO_TOKEN},
    // A held '>' is flushed by the end of the text.
    '{REQ_TEXT, CH_GT,     4'd0,  3'd0, 1'b0, NO_TOKEN},
    '{REQ_END,  CH_NUL,    4'd0,  3'd0, 1'b0, NO_TOKEN}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  keyword_token_lexer #(
    .KEYWORD_SLOTS    (SLOTS),
    .KEYWORD_MAX_CHARS(MAX_CHARS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Mirror of the lexer state, kept in step with every accepted item.
  logic [7:0]  kw_table [SLOTS][MAX_CHARS];
  logic        kw_loaded [SLOTS];
  logic [7:0]  word_chars [MAX_CHARS];
  logic        word_too_long;
  logic        in_word;
  logic [31:0] word_start;
  int          word_len;
  logic [31:0] text_pos;
  hold_t       held_op;

  // Tokens the block still owes, oldest first.
  tok_t pending_tokens[$];

  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_off_trigger;
  int cycle_count;
  int mismatches;
  int items_sent;
  int text_bytes;
  int kw_loads;
  int texts_ended;
  int tokens_checked;
  int kind_count [6];

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------

  task automatic queue_token(input tok_kind_t kind, input logic [31:0] offset, input int len,
                             input logic last);
    tok_t t;
    t.kind   = kind;
    t.offset = offset;
    t.length = (len > 65535) ? LEN_MAX : 16'(len);
    t.last   = last;
    pending_tokens = {pending_tokens, t};
  endtask

  // Kind of the word that has just ended. Only a word that fits the buffer can
  // be a keyword; it matches a loaded slot if the slot's leading bytes equal
  // the word and the slot either ends there with a zero or is full.
  function automatic tok_kind_t word_kind();
    logic same;
    if (!word_too_long && word_len >= 1 && word_len <= MAX_CHARS) begin
      for (int s = 0; s < SLOTS; s++) begin
        if (kw_loaded[s]) begin
          same = 1'b1;
          for (int i = 0; i < word_len; i++) begin
            if (kw_table[s][i] != word_chars[i]) same = 1'b0;
          end
          if (same && word_len == MAX_CHARS) return TK_KEYWORD;
          if (same && kw_table[s][word_len] == CH_NUL) return TK_KEYWORD;
        end
      end
    end
    if (word_chars[0] >= CH_DIG_0 && word_chars[0] <= CH_DIG_9) return TK_INT;
    if (word_chars[0] >= CH_LC_A && word_chars[0] <= CH_LC_Z) return TK_IDENT;
    return TK_NULL;
  endfunction

  task automatic close_word();
    if (in_word) begin
      queue_token(word_kind(), word_start, word_len, 1'b0);
      in_word       = 1'b0;
      word_len      = 0;
      word_too_long = 1'b0;
    end
  endtask

  // A held bang is dropped; any other held operator stands alone.
  task automatic release_held();
    if (held_op != HOLD_NONE && held_op != HOLD_BANG)
      queue_token(TK_OPER, text_pos - 32'd1, 1, 1'b0);
    held_op = HOLD_NONE;
  endtask

  task automatic lex_text(input logic [7:0] c);
    if (held_op != HOLD_NONE && c == CH_EQ) begin
      queue_token(TK_OPER, text_pos - 32'd1, 2, 1'b0);
      held_op  = HOLD_NONE;
      text_pos = text_pos + 32'd1;
    end else begin
      release_held();
      if ((c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_DIG_0 && c <= CH_DIG_9) ||
          c == CH_USCORE) begin
        if (!in_word) begin
          in_word       = 1'b1;
          word_start    = text_pos;
          word_len      = 0;
          word_too_long = 1'b0;
        end
        if (word_len < MAX_CHARS) word_chars[word_len] = c;
        else word_too_long = 1'b1;
        if (word_len < 65535) word_len++;
      end else begin
        close_word();
        case (c)
          CH_COMMA, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_SEMI: begin
            queue_token(TK_SEP, text_pos, 1, 1'b0);
          end
          CH_PLUS, CH_STAR, CH_SLASH, CH_MINUS: begin
            queue_token(TK_OPER, text_pos, 1, 1'b0);
          end
          CH_BANG: held_op = HOLD_BANG;
          CH_EQ:   held_op = HOLD_EQ;
          CH_LT:   held_op = HOLD_LT;
          CH_GT:   held_op = HOLD_GT;
          default: ;
        endcase
      end
      text_pos = text_pos + 32'd1;
    end
  endtask

  task automatic lex_item(input logic [1:0] req, input logic [7:0] ch, input logic [3:0] slot,
                          input logic [2:0] pos);
    case (req)
      REQ_TEXT: lex_text(ch);
      REQ_LOAD: begin
        kw_table[slot][pos] = ch;
        kw_loaded[slot]     = 1'b1;
      end
      REQ_END: begin
        release_held();
        close_word();
        queue_token(TK_NULL, text_pos, 0, 1'b1);
        text_pos   = '0;
        word_start = '0;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one item and returns at the edge where it is taken. in_tready is
  // sampled on the falling edge, when it already holds the value the next
  // rising edge will see, so acceptance never hangs on event order.
  task automatic send_item(input logic [1:0] req, input logic [7:0] ch, input logic [3:0] slot,
                           input logic [2:0] pos, input logic typed = 1'b0,
                           input tok_t tok = '0);
    logic taken;
    int   before_count;
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, pos, slot, ch};
    in_tuser  <= req;
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
    before_count = pending_tokens.size();
    lex_item(req, ch, slot, pos);
    if (typed) begin
      while (pending_tokens.size() > before_count) void'(pending_tokens.pop_back());
      pending_tokens = {pending_tokens, tok};
    end
    if (req != REQ_UNUSED) items_sent++;
    if (req == REQ_TEXT) text_bytes++;
    if (req == REQ_LOAD) kw_loads++;
    if (req == REQ_END) texts_ended++;
  endtask

  // Text bytes carry random slot and position bits, which the block ignores.
  task automatic send_text(input logic [7:0] c);
    send_item(REQ_TEXT, c, 4'($urandom_range(0, SLOTS - 1)), 3'($urandom_range(0, 7)));
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CH_LC_A + 8'($urandom_range(0, 25));
    if (r < 90) return CH_DIG_0 + 8'($urandom_range(0, 9));
    return CH_USCORE;
  endfunction

  // Sends one word. The lower variants spell a loaded keyword exactly, with
  // one byte more, or with its last byte missing; the rest make identifiers,
  // integer literals, underscore words and words too long for the buffer.
  task automatic send_word(input int variant);
    int          s;
    int          kw_len;
    int          extra;
    logic [7:0]  first;
    s      = $urandom_range(0, SLOTS - 1);
    kw_len = 0;
    while (kw_len < MAX_CHARS && kw_table[s][kw_len] != CH_NUL) kw_len++;
    if (variant <= 2 && kw_loaded[s] && kw_len > 0) begin
      for (int i = 0; i < kw_len - ((variant == 2) ? 1 : 0); i++) send_text(kw_table[s][i]);
      if (variant == 1) send_text(word_char());
    end else begin
      case (variant)
        4:       first = CH_DIG_0 + 8'($urandom_range(0, 9));
        5:       first = CH_USCORE;
        default: first = CH_LC_A + 8'($urandom_range(0, 25));
      endcase
      send_text(first);
      extra = (variant == 6) ? $urandom_range(MAX_CHARS, MAX_CHARS + 5) : $urandom_range(0, 5);
      repeat (extra) send_text(word_char());
    end
  endtask

  // Writes a whole keyword into one slot, closed by a zero if it is short.
  task automatic load_keyword();
    logic [3:0] slot;
    int         len;
    slot = 4'($urandom_range(0, SLOTS - 1));
    len  = $urandom_range(1, MAX_CHARS);
    for (int i = 0; i <= len && i < MAX_CHARS; i++) begin
      if (i == len) send_item(REQ_LOAD, CH_NUL, slot, 3'(i));
      else if ($urandom_range(0, 99) < 85)
        send_item(REQ_LOAD, CH_LC_A + 8'($urandom_range(0, 25)), slot, 3'(i));
      else send_item(REQ_LOAD, word_char(), slot, 3'(i));
    end
  endtask

  // One random step of text. Most steps are well-formed words, punctuation and
  // blanks; the remainder are stray bytes, loose loads, ignored requests and
  // ends of text.
  task automatic send_random_step();
    int pick;
    int r;
    pick = $urandom_range(0, 99);
    if (pick < 42) begin
      send_word($urandom_range(0, 6));
    end else if (pick < 62) begin
      send_text(PUNCT[$urandom_range(0, 13)]);
      if ($urandom_range(0, 99) < 35) send_text(CH_EQ);
    end else if (pick < 74) begin
      send_text(BLANKS[$urandom_range(0, 5)]);
    end else if (pick < 80) begin
      send_text(8'($urandom_range(0, 255)));
    end else if (pick < 86) begin
      r = $urandom_range(0, 99);
      send_item(REQ_LOAD,
                (r < 50) ? CH_LC_A + 8'($urandom_range(0, 25)) :
                (r < 70) ? CH_NUL : 8'($urandom_range(0, 255)),
                4'($urandom_range(0, SLOTS - 1)), 3'($urandom_range(0, 7)));
    end else if (pick < 89) begin
      send_item(REQ_UNUSED, 8'($urandom_range(0, 255)), 4'($urandom_range(0, SLOTS - 1)),
                3'($urandom_range(0, 7)));
    end else if (pick < 95) begin
      send_item(REQ_END, 8'($urandom_range(0, 255)), 4'($urandom_range(0, SLOTS - 1)),
                3'($urandom_range(0, 7)));
    end else begin
      load_keyword();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // The receiver stalls at random, and holds off for a long stretch whenever
  // the stimulus asks for it, so that the queue inside the block fills up.
  initial begin : receiver
    int stall_left;
    int seen_trigger;
    stall_left   = 0;
    seen_trigger = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_trigger != seen_trigger) begin
        seen_trigger = hold_off_trigger;
        stall_left   = HOLD_OFF_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Tokens are checked on the falling edge before the rising edge that takes
  // them; outputs do not move in between.
  always @(negedge clk) begin
    tok_t got;
    tok_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = tok_kind_t'(out_tuser);
      got.offset = out_tdata[31:0];
      got.length = out_tdata[47:32];
      got.last   = out_tlast;
      tokens_checked++;
      if (out_tuser < 3'd6) kind_count[out_tuser]++;
      if (pending_tokens.size() == 0) begin
        if (mismatches < 10)
          $display("Unexpected token at %0t: kind %0d off %0d len %0d last %0d", $time,
                   got.kind, got.offset, got.length, got.last);
        mismatches++;
      end else begin
        want = pending_tokens.pop_front();
        if (got.kind != want.kind || got.offset != want.offset ||
            got.length != want.length || got.last != want.last) begin
          if (mismatches < 10) begin
            $display("Mismatch at %0t: expected kind %0d off %0d len %0d last %0d",
                     $time, want.kind, want.offset, want.length, want.last);
            $display("  got kind %0d off %0d len %0d last %0d",
                     got.kind, got.offset, got.length, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d tokens outstanding", cycle_count,
               pending_tokens.size());
      $display("FAIL keyword_token_lexer");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int phase_end;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= REQ_TEXT;
    cycle_count      = 0;
    mismatches       = 0;
    items_sent       = 0;
    text_bytes       = 0;
    kw_loads         = 0;
    texts_ended      = 0;
    tokens_checked   = 0;
    hold_off_trigger = 0;
    for (int k = 0; k < 6; k++) kind_count[k] = 0;
    // Predictor state as it stands after reset.
    for (int s = 0; s < SLOTS; s++) begin
      kw_loaded[s] = 1'b0;
      for (int i = 0; i < MAX_CHARS; i++) kw_table[s][i] = CH_NUL;
    end
    for (int i = 0; i < MAX_CHARS; i++) word_chars[i] = CH_NUL;
    word_too_long = 1'b0;
    in_word       = 1'b0;
    word_start    = '0;
    word_len      = 0;
    text_pos      = '0;
    held_op       = HOLD_NONE;
    snd_idle_pct  = 36;
    rcv_idle_pct  = 60;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < 25; r++)
      send_item(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].slot,
                DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].tok);

    // A few whole keywords so that words have something to match from the start.
    repeat (6) load_keyword();

    // Three phases: the sender mostly idles less than the receiver, then the
    // other way round, then neither idles at random.
    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 60 : 0;
      rcv_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 36 : 0;
      if (phase != 1) hold_off_trigger++;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_random_step();
    end
    send_item(REQ_END, CH_NUL, 4'd0, 3'd0);
    in_tvalid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d text bytes, %0d keyword loads, %0d ends of text.",
             items_sent, text_bytes, kw_loads, texts_ended);
    $display("Checked %0d tokens: %0d null, %0d kw, %0d ident, %0d int, %0d sep, %0d op.",
             tokens_checked, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
             kind_count[4], kind_count[5]);
    if (mismatches == 0 && pending_tokens.size() == 0) begin
      $display("PASS keyword_token_lexer");
    end else begin
      $display("FAIL keyword_token_lexer");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/kwl_pkg.sv
hw/rtl/kwl_front.sv
hw/rtl/kwl_queue.sv
hw/rtl/kwl_back.sv
hw/rtl/keyword_token_lexer.sv
tb/sv/tb.sv
